[design/assert_macros.svh]
// Assertion macros for the checker file of the decoder.
// Each macro expects signals named clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define CBAD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define CBAD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CBAD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/cbad_pkg.sv]
// Package for the console bus address decoder: store sizes, address map
// constants, route and target codes, and the command record passed front to back.
`timescale 1ns / 1ps

package cbad_pkg;

  // Store sizes
  localparam int RAM_DEPTH     = 2048;
  localparam int EXP_DEPTH     = 8160;
  localparam int TABLE_DEPTH   = 1024;
  localparam int PALETTE_DEPTH = 32;
  localparam int NT_DEPTH      = 4 * TABLE_DEPTH;

  localparam int WRAM_AW = $clog2(RAM_DEPTH);
  localparam int EXP_AW  = $clog2(EXP_DEPTH);
  localparam int NT_AW   = $clog2(NT_DEPTH);
  localparam int TBL_AW  = $clog2(TABLE_DEPTH);
  localparam int PAL_AW  = $clog2(PALETTE_DEPTH);
  localparam int PAL_W   = 6;

  // Index field wide enough for the largest store
  localparam int IDX_W = EXP_AW;

  // Clearing pass walks the largest store
  localparam int CLR_W    = EXP_AW;
  localparam int CLR_LAST = EXP_DEPTH - 1;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Configuration port
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;
  localparam int CFG_IW  = CFG_AW - 2;
  localparam logic [CFG_IW-1:0] REG_MIRROR_MODE = CFG_IW'(0);

  // CPU map
  localparam logic [15:0] CPU_PPUREG_BASE = 16'h2000;
  localparam logic [15:0] CPU_APU_BASE    = 16'h4000;
  localparam logic [15:0] CPU_DMA_ADDR    = 16'h4014;
  localparam logic [15:0] CPU_EXP_BASE    = 16'h4020;
  localparam logic [15:0] CPU_MAPPER_BASE = 16'h6000;

  // PPU map: address bits 13..8 equal to this select the palette page
  localparam logic [5:0] PPU_PAL_PAGE = 6'h3F;

  // Name-table arrangement codes
  localparam logic [1:0] MIRROR_HORZ = 2'd0;
  localparam logic [1:0] MIRROR_VERT = 2'd1;
  localparam logic [1:0] MIRROR_FOUR = 2'd2;

  typedef enum logic [2:0] {
    ROUTE_LOCAL   = 3'd0,
    ROUTE_PPUREG  = 3'd1,
    ROUTE_DMA     = 3'd2,
    ROUTE_APU     = 3'd3,
    ROUTE_MAPPER  = 3'd4,
    ROUTE_INVALID = 3'd5
  } route_t;

  typedef enum logic [2:0] {
    TGT_NONE = 3'd0,
    TGT_WRAM = 3'd1,
    TGT_EXP  = 3'd2,
    TGT_NTAB = 3'd3,
    TGT_PAL  = 3'd4
  } tgt_t;

  typedef struct packed {
    tgt_t             tgt;
    logic             wr;
    logic [IDX_W-1:0] idx;
    logic [7:0]       wdata;
    route_t           route;
    logic [2:0]       ppu_reg;
    logic [15:0]      fwd_addr;
    logic [7:0]       fwd_data;
  } cmd_t;

  typedef struct packed {
    logic avail;
    cmd_t cmd;
  } q_head_t;

endpackage

[design/cbad_in_if.sv]
// Input channel of the decoder: one byte access per transfer.
// Stands alone; no package needed.
`timescale 1ns / 1ps

interface cbad_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic        bus_map;
  logic [15:0] bus_addr;
  logic [7:0]  wr_data;

  modport source (output valid, func, bus_map, bus_addr, wr_data, input ready);
  modport sink   (input valid, func, bus_map, bus_addr, wr_data, output ready);
endinterface

[design/cbad_out_if.sv]
// Result channel of the decoder: one result per access.
// Stands alone; no package needed.
`timescale 1ns / 1ps

interface cbad_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rd_data;
  logic [2:0]  route;
  logic [2:0]  ppu_reg;
  logic [15:0] fwd_addr;
  logic [7:0]  fwd_data;

  modport source (output valid, rd_data, route, ppu_reg, fwd_addr, fwd_data, input ready);
  modport sink   (input valid, rd_data, route, ppu_reg, fwd_addr, fwd_data, output ready);
endinterface

[design/cbad_ram.sv]
// Generic single-port RAM with registered read; read data holds between reads.
// No package dependency.
`timescale 1ns / 1ps

module cbad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/cbad_front.sv]
// Front end: accepts accesses and classifies them into store commands and routes.
// Depends on cbad_pkg and cbad_in_if.
`timescale 1ns / 1ps

module cbad_front (
  cbad_in_if.sink           in_ch,
  input  logic [1:0]        mirror_mode,
  input  logic              clr_busy,
  input  logic              q_full,
  output logic              push,
  output cbad_pkg::cmd_t    cmd
);
  import cbad_pkg::*;

  logic [15:0]       addr;
  logic [15:0]       exp_off;
  logic [PAL_AW-1:0] pal_idx;
  logic [1:0]        bank;
  logic [1:0]        tsel;

  assign in_ch.ready = !clr_busy && !q_full;
  assign push        = in_ch.valid && in_ch.ready;

  assign addr    = in_ch.bus_addr;
  assign exp_off = addr - CPU_EXP_BASE;
  assign bank    = addr[TBL_AW+1:TBL_AW];

  // Fold the mirrored palette backdrop entries onto the lower half
  always_comb begin
    pal_idx = addr[PAL_AW-1:0];
    if (pal_idx[PAL_AW-1] && (pal_idx[1:0] == 2'b00)) begin
      pal_idx[PAL_AW-1] = 1'b0;
    end
  end

  always_comb begin
    unique case (mirror_mode)
      MIRROR_HORZ: tsel = {1'b0, bank[1]};
      MIRROR_VERT: tsel = {1'b0, bank[0]};
      default:     tsel = bank;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.tgt   = TGT_NONE;
    cmd.route = ROUTE_LOCAL;
    cmd.wr    = in_ch.func;
    cmd.wdata = in_ch.wr_data;
    if (!in_ch.bus_map) begin
      if (addr < CPU_PPUREG_BASE) begin
        cmd.tgt = TGT_WRAM;
        cmd.idx = IDX_W'(addr[WRAM_AW-1:0]);
      end else if (addr < CPU_APU_BASE) begin
        cmd.route   = ROUTE_PPUREG;
        cmd.ppu_reg = addr[2:0];
      end else if (addr == CPU_DMA_ADDR) begin
        cmd.route = in_ch.func ? ROUTE_DMA : ROUTE_INVALID;
      end else if (addr < CPU_EXP_BASE) begin
        cmd.route = ROUTE_APU;
      end else if (addr < CPU_MAPPER_BASE) begin
        cmd.tgt = TGT_EXP;
        cmd.idx = exp_off[IDX_W-1:0];
      end else begin
        cmd.route    = ROUTE_MAPPER;
        cmd.fwd_addr = addr;
      end
    end else begin
      if (!addr[13]) begin
        cmd.route    = ROUTE_MAPPER;
        cmd.fwd_addr = {3'b000, addr[12:0]};
      end else if (addr[13:8] == PPU_PAL_PAGE) begin
        cmd.tgt   = TGT_PAL;
        cmd.idx   = IDX_W'(pal_idx);
        cmd.wdata = {2'b00, in_ch.wr_data[PAL_W-1:0]};
      end else begin
        cmd.tgt = TGT_NTAB;
        cmd.idx = IDX_W'({tsel, addr[TBL_AW-1:0]});
      end
    end
    // Hand the byte on for writes on the register, DMA and mapper routes
    if (in_ch.func && ((cmd.route == ROUTE_PPUREG) || (cmd.route == ROUTE_DMA)
                       || (cmd.route == ROUTE_MAPPER))) begin
      cmd.fwd_data = in_ch.wr_data;
    end
  end

endmodule

[design/cbad_queue.sv]
// Two-entry command queue between the front end and the back end.
// Depends on cbad_pkg.
`timescale 1ns / 1ps

module cbad_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  cbad_pkg::cmd_t     push_cmd,
  input  logic               pop,
  output logic               full,
  output cbad_pkg::q_head_t  head
);
  import cbad_pkg::*;

  cmd_t            entry_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] count_r, count_nxt;

  assign full       = (count_r == Q_CW'(Q_DEPTH));
  assign head.avail = (count_r != '0);
  assign head.cmd   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + Q_AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + Q_AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + Q_CW'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[design/cbad_back.sv]
// Back end: clears the stores after reset, then carries out queued commands
// on the four stores and holds each result in the output register.
// Depends on cbad_pkg, cbad_ram and cbad_out_if.
`timescale 1ns / 1ps

module cbad_back (
  input  logic               clk,
  input  logic               rst_n,
  input  cbad_pkg::q_head_t  head,
  output logic               pop,
  output logic               clr_busy,
  cbad_out_if.source         out_ch
);
  import cbad_pkg::*;

  logic             clr_busy_r, clr_busy_nxt;
  logic [CLR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  cmd_t             out_cmd_r, out_cmd_nxt;
  logic             issue;
  cmd_t             hc;

  logic               wram_we, wram_re, exp_we, exp_re, nt_we, nt_re, pal_we, pal_re;
  logic [WRAM_AW-1:0] wram_addr;
  logic [EXP_AW-1:0]  exp_addr;
  logic [NT_AW-1:0]   nt_addr;
  logic [PAL_AW-1:0]  pal_addr;
  logic [7:0]         store_wdata;
  logic [7:0]         wram_q, exp_q, nt_q;
  logic [PAL_W-1:0]   pal_q;

  assign hc       = head.cmd;
  assign clr_busy = clr_busy_r;
  assign issue    = !clr_busy_r && head.avail && (!out_valid_r || out_ch.ready);
  assign pop      = issue;

  // Clearing pass: one entry per cycle of each store, up to that store's depth
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clr_busy_r) begin
      if (clr_cnt_r == CLR_W'(CLR_LAST)) begin
        clr_busy_nxt = 1'b0;
      end else begin
        clr_cnt_nxt = clr_cnt_r + CLR_W'(1);
      end
    end
  end

  always_comb begin
    if (clr_busy_r) begin
      wram_we     = ({1'b0, clr_cnt_r} < (CLR_W+1)'(RAM_DEPTH));
      exp_we      = ({1'b0, clr_cnt_r} < (CLR_W+1)'(EXP_DEPTH));
      nt_we       = ({1'b0, clr_cnt_r} < (CLR_W+1)'(NT_DEPTH));
      pal_we      = ({1'b0, clr_cnt_r} < (CLR_W+1)'(PALETTE_DEPTH));
      wram_addr   = clr_cnt_r[WRAM_AW-1:0];
      exp_addr    = clr_cnt_r[EXP_AW-1:0];
      nt_addr     = clr_cnt_r[NT_AW-1:0];
      pal_addr    = clr_cnt_r[PAL_AW-1:0];
      store_wdata = '0;
    end else begin
      wram_we     = issue && hc.wr && (hc.tgt == TGT_WRAM);
      exp_we      = issue && hc.wr && (hc.tgt == TGT_EXP);
      nt_we       = issue && hc.wr && (hc.tgt == TGT_NTAB);
      pal_we      = issue && hc.wr && (hc.tgt == TGT_PAL);
      wram_addr   = hc.idx[WRAM_AW-1:0];
      exp_addr    = hc.idx[EXP_AW-1:0];
      nt_addr     = hc.idx[NT_AW-1:0];
      pal_addr    = hc.idx[PAL_AW-1:0];
      store_wdata = hc.wdata;
    end
  end

  assign wram_re = issue && !hc.wr && (hc.tgt == TGT_WRAM);
  assign exp_re  = issue && !hc.wr && (hc.tgt == TGT_EXP);
  assign nt_re   = issue && !hc.wr && (hc.tgt == TGT_NTAB);
  assign pal_re  = issue && !hc.wr && (hc.tgt == TGT_PAL);

  cbad_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_wram (
    .clk(clk), .we(wram_we), .re(wram_re), .addr(wram_addr),
    .wdata(store_wdata), .rdata(wram_q)
  );

  cbad_ram #(.WIDTH(8), .DEPTH(EXP_DEPTH)) u_exp (
    .clk(clk), .we(exp_we), .re(exp_re), .addr(exp_addr),
    .wdata(store_wdata), .rdata(exp_q)
  );

  cbad_ram #(.WIDTH(8), .DEPTH(NT_DEPTH)) u_ntab (
    .clk(clk), .we(nt_we), .re(nt_re), .addr(nt_addr),
    .wdata(store_wdata), .rdata(nt_q)
  );

  cbad_ram #(.WIDTH(PAL_W), .DEPTH(PALETTE_DEPTH)) u_pal (
    .clk(clk), .we(pal_we), .re(pal_re), .addr(pal_addr),
    .wdata(store_wdata[PAL_W-1:0]), .rdata(pal_q)
  );

  // Output register; loads at the same edge as the store read, so read data lines up
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_cmd_nxt   = out_cmd_r;
    if (issue) begin
      out_valid_nxt = 1'b1;
      out_cmd_nxt   = hc;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_busy_r  <= clr_busy_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_cmd_r <= out_cmd_nxt;
  end

  always_comb begin
    out_ch.rd_data = '0;
    if (!out_cmd_r.wr) begin
      unique case (out_cmd_r.tgt)
        TGT_WRAM: out_ch.rd_data = wram_q;
        TGT_EXP:  out_ch.rd_data = exp_q;
        TGT_NTAB: out_ch.rd_data = nt_q;
        TGT_PAL:  out_ch.rd_data = {2'b00, pal_q};
        default:  out_ch.rd_data = '0;
      endcase
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.route    = out_cmd_r.route;
  assign out_ch.ppu_reg  = out_cmd_r.ppu_reg;
  assign out_ch.fwd_addr = out_cmd_r.fwd_addr;
  assign out_ch.fwd_data = out_cmd_r.fwd_data;

endmodule

[design/console_bus_address_decoder.sv]
// Channel   | Dir | Transfer                | Payload
// in_ch     | in  | valid & ready           | func, bus_map, bus_addr, wr_data
// out_ch    | out | valid & ready           | rd_data, route, ppu_reg, fwd_addr, fwd_data
// cfg_*     | in  | psel & penable & pwrite | register 0 mirror_mode at byte address 0
//
// One access per clock sustained while out_ch accepts; an input transfer writes
// its command into the queue, the queued command then issues, and the store read
// and output register load at the same edge. Each store has a single port, one
// access per cycle. After reset a clearing pass zeroes all stores; in_ch.ready
// stays low meanwhile. A stalled output fills the two-entry queue, then
// in_ch.ready drops.
// Top level: front end, queue and back end plus the mirror_mode register.
// Depends on cbad_pkg, cbad_in_if, cbad_out_if, cbad_front, cbad_queue, cbad_back.
`timescale 1ns / 1ps

module console_bus_address_decoder (
  input  logic                        clk,
  input  logic                        rst_n,
  cbad_in_if.sink                     in_ch,
  cbad_out_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [cbad_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [cbad_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [cbad_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import cbad_pkg::*;

  logic [1:0]  mode_r, mode_nxt;
  logic        cfg_wr;
  logic        cfg_hit;
  logic        push;
  logic        pop;
  logic        q_full;
  logic        clr_busy;
  cmd_t        push_cmd;
  q_head_t     q_head;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[CFG_AW-1:2] == REG_MIRROR_MODE);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_hit ? CFG_DW'(mode_r) : '0;

  always_comb begin
    mode_nxt = mode_r;
    if (cfg_wr && cfg_hit) begin
      mode_nxt = cfg_pwdata[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MIRROR_HORZ;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  cbad_front u_front (
    .in_ch       (in_ch),
    .mirror_mode (mode_r),
    .clr_busy    (clr_busy),
    .q_full      (q_full),
    .push        (push),
    .cmd         (push_cmd)
  );

  cbad_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .head     (q_head)
  );

  cbad_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (q_head),
    .pop      (pop),
    .clr_busy (clr_busy),
    .out_ch   (out_ch)
  );

endmodule

[design/cbad_checker.sv]
// Port-level checks on the decoder's result channel, bound to the top level.
// Depends on cbad_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cbad_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_rd_data,
  input logic [2:0]  out_route,
  input logic [2:0]  out_ppu_reg,
  input logic [15:0] out_fwd_addr
);
  import cbad_pkg::*;

  // A stalled result stays valid on the port with its route unchanged
  `CBAD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_route), "stalled result changed")

  `CBAD_ASSERT_IMP(a_ppu_reg_zero, out_valid && (out_route != ROUTE_PPUREG), out_ppu_reg == 3'd0, "register index set off the register route")

  `CBAD_ASSERT_IMP(a_rd_zero, out_valid && (out_route != ROUTE_LOCAL), out_rd_data == 8'd0, "read data on a forwarded route")

  `CBAD_ASSERT_IMP(a_fwd_addr_zero, out_valid && (out_route != ROUTE_MAPPER), out_fwd_addr == 16'd0, "forward address off the mapper route")

endmodule

bind console_bus_address_decoder cbad_checker u_cbad_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_rd_data  (out_ch.rd_data),
  .out_route    (out_ch.route),
  .out_ppu_reg  (out_ch.ppu_reg),
  .out_fwd_addr (out_ch.fwd_addr)
);

[verif/console_bus_address_decoder_tb.sv]
// Testbench for console_bus_address_decoder: drives CPU and PPU byte accesses, checks
// results in order against directed rows or predictions from a local copy of the stores.
// Depends on cbad_pkg, cbad_in_if, cbad_out_if and the decoder RTL.
`timescale 1ns / 1ps

module console_bus_address_decoder_tb;
  import cbad_pkg::*;

  localparam logic FN_READ  = 1'b0;
  localparam logic FN_WRITE = 1'b1;
  localparam logic MAP_CPU  = 1'b0;
  localparam logic MAP_PPU  = 1'b1;

  localparam logic [1:0] MIRROR_SPARE = 2'd3;
  localparam logic [CFG_IW-1:0] REG_UNUSED = CFG_IW'(1);

  localparam int POOL_SIZE     = 16;
  localparam int N_DIRECTED    = 25;
  localparam int N_PHASES      = 5;
  localparam int PHASE_ITEMS   = 180;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD     = 400;

  typedef struct packed {
    logic        func;
    logic        bus_map;
    logic [15:0] bus_addr;
    logic [7:0]  wr_data;
  } access_t;

  typedef struct packed {
    logic [7:0]  rd_data;
    route_t      route;
    logic [2:0]  ppu_reg;
    logic [15:0] fwd_addr;
    logic [7:0]  fwd_data;
  } result_t;

  // One directed row; the expected result is used only where known is set
  typedef struct packed {
    logic        func;
    logic        bus_map;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        known;
    logic [7:0]  rd;
    route_t      route;
    logic [2:0]  reg_idx;
    logic [15:0] faddr;
    logic [7:0]  fdata;
  } probe_t;

  localparam probe_t DIRECTED_ACCESSES [N_DIRECTED] = '{
    '{FN_READ,  MAP_CPU, 16'h0000, 8'h00, 1'b1, 8'h00, ROUTE_LOCAL,   3'd0, 16'h0000, 8'h00},
    '{FN_WRITE, MAP_CPU, 16'h0000, 8'hFF, 1'b1, 8'h00, ROUTE_LOCAL,   3'd0, 16'h0000, 8'h00},
    '{FN_READ,  MAP_CPU, 16'h1800, 8'h00, 1'b1, 8'hFF, ROUTE_LOCAL,   3'd0, 16'h0000, 8'h00},
    '{FN_WRITE, MAP_CPU, 16'h2000, 8'hA5, 1'b1, 8'h00, ROUTE_PPUREG,  3'd0, 16'h0000, 8'hA5},
    '{FN_READ,  MAP_CPU, 16'h3FFF, 8'h00, 1'b1, 8'h00, ROUTE_PPUREG,  3'd7, 16'h0000, 8'h00},
    '{FN_WRITE, MAP_CPU, 16'h4014, 8'h3C, 1'b1, 8'h00, ROUTE_DMA,     3'd0, 16'h0000, 8'h3C},
    '{FN_READ,  MAP_CPU, 16'h4014, 8'h00, 1'b1, 8'h00, ROUTE_INVALID, 3'd0, 16'h0000, 8'h00},
    '{FN_WRITE, MAP_CPU, 16'h4000, 8'h55, 1'b1, 8'h00, ROUTE_APU,     3'd0, 16'h0000, 8'h00},
    '{FN_READ,  MAP_CPU, 16'h401F, 8'h00, 1'b1, 8'h00, ROUTE_APU,     3'd0, 16'h0000, 8'h00},
    '{FN_WRITE, MAP_CPU, 16'h4020, 8'h81, 1'b0, 8'h00, ROUTE_LOCAL,   3'd0, 16'h0000, 8'h00},
    '{FN_READ,  MAP_CPU, 16'h4020, 8'h00, 1'b0, 8'h00, ROUTE_LOCAL,   3'd0, 16'h0000, 8'h00},
    '{FN_WRITE, MAP_CPU, 16'h5FFF, 8'h7E, 1'b0, 8'h00, ROUTE_LOCAL,   3'd0, 16'h0000, 8'h00},
    '{FN_READ,  MAP_CPU, 16'h5FFF, 8'h00, 1'b0, 8'h00, ROUTE_LOCAL,   3'd0, 16'h0000, 8'h00},
    '{FN_WRITE, MAP_CPU, 16'h6000, 8'h12, 1'b1, 8'h00, ROUTE_MAPPER,  3'd0, 16'h6000, 8'h12},
    '{FN_READ,  MAP_CPU, 16'hFFFF, 8'h00, 1'b1, 8'h00, ROUTE_MAPPER,  3'd0, 16'hFFFF, 8'h00},
    '{FN_WRITE, MAP_PPU, 16'h0000, 8'hEE, 1'b1, 8'h00, ROUTE_MAPPER,  3'd0, 16'h0000, 8'hEE},
    '{FN_READ,  MAP_PPU, 16'hDFFF, 8'h00, 1'b1, 8'h00, ROUTE_MAPPER,  3'd0, 16'h1FFF, 8'h00},
    '{FN_WRITE, MAP_PPU, 16'h2000, 8'h5A, 1'b0, 8'h00, ROUTE_LOCAL,   3'd0, 16'h0000, 8'h00},
    '{FN_READ,  MAP_PPU, 16'h2400, 8'h00, 1'b0, 8'h00, ROUTE_LOCAL,   3'd0, 16'h0000, 8'h00},
    '{FN_READ,  MAP_PPU, 16'h2800, 8'h00, 1'b1, 8'h00, ROUTE_LOCAL,   3'd0, 16'h0000, 8'h00},
    '{FN_WRITE, MAP_PPU, 16'h3EFF, 8'hC3, 1'b0, 8'h00, ROUTE_LOCAL,   3'd0, 16'h0000, 8'h00},
    '{FN_READ,  MAP_PPU, 16'h3EFF, 8'h00, 1'b0, 8'h00, ROUTE_LOCAL,   3'd0, 16'h0000, 8'h00},
    '{FN_WRITE, MAP_PPU, 16'h3F10, 8'hFF, 1'b0, 8'h00, ROUTE_LOCAL,   3'd0, 16'h0000, 8'h00},
    '{FN_READ,  MAP_PPU, 16'h3F00, 8'h00, 1'b1, 8'h3F, ROUTE_LOCAL,   3'd0, 16'h0000, 8'h00},
    '{FN_READ,  MAP_PPU, 16'hFF1C, 8'h00, 1'b0, 8'h00, ROUTE_LOCAL,   3'd0, 16'h0000, 8'h00}
  };

  localparam logic [1:0] PHASE_MODES [N_PHASES] = '{
    MIRROR_VERT, MIRROR_FOUR, MIRROR_SPARE, MIRROR_HORZ, MIRROR_FOUR
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  cbad_in_if  in_ch ();
  cbad_out_if out_ch ();

  console_bus_address_decoder u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the decoder state
  logic [7:0]       wram_copy  [RAM_DEPTH];
  logic [7:0]       exp_copy   [EXP_DEPTH];
  logic [7:0]       ntab_copy  [NT_DEPTH];
  logic [PAL_W-1:0] pal_copy   [PALETTE_DEPTH];
  logic [1:0]       mirror_copy;

  result_t     pending_results [$];
  int          mismatch_count = 0;
  int          burst_left = 0;
  bit          gapless = 1'b0;
  bit          hold_request = 1'b0;

  // Recently written locations, reused to read back through mirrors
  logic        pool_map  [POOL_SIZE];
  logic [15:0] pool_addr [POOL_SIZE];
  int          pool_wr = 0;

  function automatic result_t decode_access(input access_t a);
    result_t     r;
    logic [15:0] pa;
    logic [4:0]  pe;
    logic [1:0]  bank;
    logic [1:0]  tbl;
    int          idx;
    r.rd_data  = 8'h00;
    r.route    = ROUTE_LOCAL;
    r.ppu_reg  = 3'd0;
    r.fwd_addr = 16'h0000;
    r.fwd_data = 8'h00;
    if (a.bus_map == MAP_CPU) begin
      if (a.bus_addr < CPU_PPUREG_BASE) begin
        idx = a.bus_addr % RAM_DEPTH;
        if (a.func == FN_WRITE) wram_copy[idx] = a.wr_data;
        else r.rd_data = wram_copy[idx];
      end else if (a.bus_addr < CPU_APU_BASE) begin
        r.route   = ROUTE_PPUREG;
        r.ppu_reg = a.bus_addr[2:0];
      end else if (a.bus_addr == CPU_DMA_ADDR) begin
        r.route = (a.func == FN_WRITE) ? ROUTE_DMA : ROUTE_INVALID;
      end else if (a.bus_addr < CPU_EXP_BASE) begin
        r.route = ROUTE_APU;
      end else if (a.bus_addr < CPU_MAPPER_BASE) begin
        idx = a.bus_addr - CPU_EXP_BASE;
        if (a.func == FN_WRITE) exp_copy[idx] = a.wr_data;
        else r.rd_data = exp_copy[idx];
      end else begin
        r.route    = ROUTE_MAPPER;
        r.fwd_addr = a.bus_addr;
      end
    end else begin
      pa = {2'b00, a.bus_addr[13:0]};
      if (pa < CPU_PPUREG_BASE) begin
        r.route    = ROUTE_MAPPER;
        r.fwd_addr = pa;
      end else if (pa[13:8] == PPU_PAL_PAGE) begin
        pe = pa[4:0];
        // backdrop entries of the sprite half alias the background half
        if (pe[4] && pe[1:0] == 2'b00) pe[4] = 1'b0;
        if (a.func == FN_WRITE) pal_copy[pe] = a.wr_data[PAL_W-1:0];
        else r.rd_data = {2'b00, pal_copy[pe]};
      end else begin
        bank = pa[11:10];
        if (mirror_copy == MIRROR_HORZ) tbl = {1'b0, bank[1]};
        else if (mirror_copy == MIRROR_VERT) tbl = {1'b0, bank[0]};
        else tbl = bank;
        idx = tbl * TABLE_DEPTH + pa[9:0];
        if (a.func == FN_WRITE) ntab_copy[idx] = a.wr_data;
        else r.rd_data = ntab_copy[idx];
      end
    end
    if (a.func == FN_WRITE) begin
      r.rd_data = 8'h00;
      if (r.route == ROUTE_PPUREG || r.route == ROUTE_DMA || r.route == ROUTE_MAPPER)
        r.fwd_data = a.wr_data;
    end
    return r;
  endfunction

  function automatic access_t next_access();
    access_t     a;
    logic [31:0] rnd;
    int          pick;
    int          slot;
    pick = $urandom_range(0, 99);
    rnd  = $urandom;
    a.func     = rnd[0];
    a.wr_data  = rnd[15:8];
    a.bus_map  = MAP_CPU;
    a.bus_addr = rnd[31:16];
    if (pick < 35) begin
      // revisit a written location, mostly to read it back through a mirror
      slot       = $urandom_range(0, POOL_SIZE - 1);
      a.bus_map  = pool_map[slot];
      a.bus_addr = pool_addr[slot];
      a.func     = (pick < 8) ? FN_WRITE : FN_READ;
      if (a.bus_map == MAP_PPU) begin
        a.bus_addr[15:14] = rnd[2:1];
        if (rnd[5]) a.bus_addr[11:10] = rnd[4:3];
      end else if (a.bus_addr < CPU_PPUREG_BASE) begin
        a.bus_addr[12:11] = rnd[4:3];
      end
    end else if (pick < 45) begin
      a.bus_addr = {3'b000, rnd[28:16]};
    end else if (pick < 52) begin
      a.bus_addr = {3'b001, rnd[28:16]};
    end else if (pick < 60) begin
      a.bus_addr = rnd[5] ? CPU_DMA_ADDR : (CPU_APU_BASE | {11'd0, rnd[20:16]});
    end else if (pick < 67) begin
      a.bus_addr = CPU_EXP_BASE + 16'($urandom_range(0, EXP_DEPTH - 1));
    end else if (pick < 72) begin
      a.bus_addr = CPU_MAPPER_BASE + 16'($urandom_range(0, 16'hFFFF - CPU_MAPPER_BASE));
    end else if (pick < 77) begin
      a.bus_map  = MAP_PPU;
      a.bus_addr = {rnd[31:30], 1'b0, rnd[28:16]};
    end else if (pick < 88) begin
      a.bus_map  = MAP_PPU;
      a.bus_addr = {rnd[31:30], 1'b1, rnd[28:16]};
      if (a.bus_addr[13:8] == PPU_PAL_PAGE) a.bus_addr[8] = 1'b0;
    end else if (pick < 95) begin
      a.bus_map  = MAP_PPU;
      a.bus_addr = {rnd[31:30], PPU_PAL_PAGE, rnd[23:16]};
    end else begin
      a.bus_map = rnd[7];
    end
    if (a.func == FN_WRITE) begin
      pool_map[pool_wr]  = a.bus_map;
      pool_addr[pool_wr] = a.bus_addr;
      pool_wr = (pool_wr + 1) % POOL_SIZE;
    end
    return a;
  endfunction

  task automatic send_access(input access_t a, input logic known, input result_t want);
    result_t got;
    in_ch.valid    <= 1'b1;
    in_ch.func     <= a.func;
    in_ch.bus_map  <= a.bus_map;
    in_ch.bus_addr <= a.bus_addr;
    in_ch.wr_data  <= a.wr_data;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    got = decode_access(a);
    pending_results.push_back(known ? want : got);
    if (!gapless) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(0, 24);
      end
    end
  endtask

  // Hold the input idle until every result is in, then let the pipeline settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_MIRROR_MODE) mirror_copy = value[1:0];
  endtask

  // Result side: stall pattern switches at random among four styles, long hold on request
  initial begin
    int hold_left;
    int style;
    int style_left;
    int tick;
    hold_left  = 0;
    style      = 0;
    style_left = 0;
    tick       = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (style_left == 0) begin
        style      = $urandom_range(0, 3);
        style_left = $urandom_range(64, 256);
      end
      style_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (style)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= $urandom_range(0, 1);
          2: out_ch.ready <= (tick % 4 == 0);
          default: out_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: route %0d rd_data %0h", out_ch.route, out_ch.rd_data);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.rd_data !== want.rd_data) begin
          $error("rd_data: expected %0h, actual %0h", want.rd_data, out_ch.rd_data);
          mismatch_count++;
        end
        if (out_ch.route !== 3'(want.route)) begin
          $error("route: expected %0d, actual %0d", want.route, out_ch.route);
          mismatch_count++;
        end
        if (out_ch.ppu_reg !== want.ppu_reg) begin
          $error("ppu_reg: expected %0d, actual %0d", want.ppu_reg, out_ch.ppu_reg);
          mismatch_count++;
        end
        if (out_ch.fwd_addr !== want.fwd_addr) begin
          $error("fwd_addr: expected %0h, actual %0h", want.fwd_addr, out_ch.fwd_addr);
          mismatch_count++;
        end
        if (out_ch.fwd_data !== want.fwd_data) begin
          $error("fwd_data: expected %0h, actual %0h", want.fwd_data, out_ch.fwd_data);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("FAIL console_bus_address_decoder");
    $finish;
  end

  initial begin
    access_t acc;
    result_t want;
    result_t none;
    probe_t  row;
    none = '{8'h00, ROUTE_LOCAL, 3'd0, 16'h0000, 8'h00};
    foreach (wram_copy[i]) wram_copy[i] = 8'h00;
    foreach (exp_copy[i]) exp_copy[i] = 8'h00;
    foreach (ntab_copy[i]) ntab_copy[i] = 8'h00;
    foreach (pal_copy[i]) pal_copy[i] = '0;
    foreach (pool_addr[i]) begin
      pool_map[i]  = MAP_CPU;
      pool_addr[i] = 16'h0000;
    end
    mirror_copy = MIRROR_HORZ;

    in_ch.valid    <= 1'b0;
    in_ch.func     <= FN_READ;
    in_ch.bus_map  <= MAP_CPU;
    in_ch.bus_addr <= 16'h0000;
    in_ch.wr_data  <= 8'h00;
    cfg_psel       <= 1'b0;
    cfg_penable    <= 1'b0;
    cfg_pwrite     <= 1'b0;
    cfg_paddr      <= '0;
    cfg_pwdata     <= '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows run under the reset arrangement
    for (int i = 0; i < N_DIRECTED; i++) begin
      row  = DIRECTED_ACCESSES[i];
      acc  = '{row.func, row.bus_map, row.addr, row.data};
      want = '{row.rd, row.route, row.reg_idx, row.faddr, row.fdata};
      send_access(acc, row.known, want);
    end
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(REG_MIRROR_MODE, CFG_DW'(PHASE_MODES[p]));
      // writes to the unused index must leave the arrangement alone
      if (p == 2) write_reg(REG_UNUSED, CFG_DW'($urandom_range(0, 3)));
      if (p == 1) hold_request = 1'b1;
      gapless    = (p == 3);
      burst_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) send_access(next_access(), 1'b0, none);
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS console_bus_address_decoder");
    end else begin
      $display("FAIL console_bus_address_decoder");
    end
    $finish;
  end

endmodule
